FILE: hdl/ppce_pkg.sv
package ppce_pkg;

    // Fixed field widths
    localparam int SAMPLE_W     = 16;
    localparam int SUM_W        = 25;
    localparam int SMOOTH_OUT_W = 23;
    localparam int TIME_W       = 10;
    localparam int IDX_W        = 8;
    localparam int CFG_W        = 8;
    localparam int SMOOTH_LEN_W = 7;
    localparam int CFG_IDX_W    = 2;
    // Width of the half-sample time arithmetic
    localparam int HT_W         = 12;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_LEN      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_HALF_WIDTH = 2'd3;

    // Register reset values
    localparam logic [CFG_W-1:0]        RST_WINDOW_START    = 8'd0;
    localparam logic [CFG_W-1:0]        RST_WINDOW_END      = 8'd200;
    localparam logic [SMOOTH_LEN_W-1:0] RST_SMOOTH_LEN      = 7'd1;
    localparam logic [CFG_W-1:0]        RST_PEAK_HALF_WIDTH = 8'd20;

    typedef struct packed {
        logic [CFG_W-1:0]        window_start;
        logic [CFG_W-1:0]        window_end;
        logic [SMOOTH_LEN_W-1:0] smooth_len;
        logic [CFG_W-1:0]        peak_half_width;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SAMPLE,
        S_CALC,
        S_RD_WE,
        S_RD_WS,
        S_RD_HI,
        S_RD_LO,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        RD_SMOOTH,
        RD_WE,
        RD_WS,
        RD_HI,
        RD_LO
    } t_rd_sel;

    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_WE,
        CAP_WS,
        CAP_HI
    } t_cap;

    typedef struct packed {
        logic    accept;
        logic    update;
        logic    calc;
        logic    rd_en;
        t_rd_sel rd_sel;
        t_cap    cap;
        logic    finish;
    } t_cmd;

endpackage

FILE: hdl/ppce_ctrl.sv
module ppce_ctrl
    import ppce_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_is_last,
    output logic o_busy,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_last;
    logic   r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_OUT);
            if (o_cmd.accept) begin
                r_last <= i_is_last;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.rd_sel = RD_SMOOTH;
        o_cmd.cap    = CAP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_SMOOTH;
                    n_state      = S_SAMPLE;
                end
            end
            S_SAMPLE: begin
                o_cmd.update = 1'b1;
                n_state      = r_last ? S_CALC : S_IDLE;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_RD_WE;
            end
            S_RD_WE: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_WE;
                n_state      = S_RD_WS;
            end
            S_RD_WS: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_WS;
                o_cmd.cap    = CAP_WE;
                n_state      = S_RD_HI;
            end
            S_RD_HI: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_HI;
                o_cmd.cap    = CAP_WS;
                n_state      = S_RD_LO;
            end
            S_RD_LO: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_LO;
                o_cmd.cap    = CAP_HI;
                n_state      = S_OUT;
            end
            S_OUT: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

FILE: hdl/ppce_dp.sv
module ppce_dp
    import ppce_pkg::*;
#(
    parameter int MAX_SAMPLES = 256,
    parameter int MAX_SMOOTH  = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cmd                           i_cmd,
    input  t_cfg                           i_cfg,
    input  logic signed [SAMPLE_W-1:0]     i_sample_value,
    output logic signed [SAMPLE_W-1:0]     o_peak_amplitude,
    output logic        [IDX_W-1:0]        o_peak_index,
    output logic signed [SMOOTH_OUT_W-1:0] o_smooth_peak_sum,
    output logic signed [TIME_W-1:0]       o_smooth_peak_half_time,
    output logic signed [SUM_W-1:0]        o_window_sum,
    output logic signed [SUM_W-1:0]        o_peak_window_sum,
    output logic                           o_window_ok,
    output logic                           o_smooth_ok,
    output logic                           o_peak_window_ok,
    output logic                           o_trace_overflow
);

    localparam int AW     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW     = $clog2(MAX_SAMPLES + 1);
    localparam int IW     = (AW + 2 > HT_W + 1) ? AW + 2 : HT_W + 1;
    localparam int NS_CAP = (MAX_SMOOTH > 127) ? 127 : MAX_SMOOTH;

    function automatic logic [SUM_W:0] mag_sum(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W:0] e;
        e = {v[SUM_W-1], v};
        return v[SUM_W-1] ? -e : e;
    endfunction

    function automatic logic [SAMPLE_W:0] mag_smp(input logic signed [SAMPLE_W-1:0] v);
        logic signed [SAMPLE_W:0] e;
        e = {v[SAMPLE_W-1], v};
        return v[SAMPLE_W-1] ? -e : e;
    endfunction

    // Halve, rounding toward zero
    function automatic logic signed [HT_W-1:0] half_trunc(input logic signed [HT_W-1:0] v);
        logic signed [HT_W-1:0] p;
        p = -v;
        return v[HT_W-1] ? -(p >>> 1) : (v >>> 1);
    endfunction

    // Prefix-sum store
    logic signed [SUM_W-1:0] mem [MAX_SAMPLES];
    logic signed [SUM_W-1:0] r_rd_data;
    logic                    r_rd_zero;

    // Per-trace state
    logic signed [SUM_W-1:0]    r_total;
    logic        [CW-1:0]       r_cnt;
    logic signed [SAMPLE_W-1:0] r_bamp;
    logic        [IDX_W-1:0]    r_bidx;
    logic signed [SUM_W-1:0]    r_bsum;
    logic        [IDX_W-1:0]    r_bsidx;
    logic                       r_ovf;
    logic signed [SAMPLE_W-1:0] r_x;

    // End-of-trace results
    logic                    r_wok, r_sok, r_pok;
    logic signed [HT_W-1:0]  r_h, r_lowb, r_hib;
    logic signed [SUM_W-1:0] r_pa, r_pb, r_pc;

    logic [SMOOTH_LEN_W-1:0] ns;
    logic signed [IW-1:0]    k_s, i_s, ws_s, we_s, ns_s, rd_idx;
    logic signed [SUM_W-1:0] rd_val, total_n, m;
    logic                    cnt_ok;
    logic signed [HT_W-1:0]  h_c, lo_half, hi_half, lowb_c, hib_c;
    logic                    wok_c, sok_c, pok_c;

    assign ns = (int'(i_cfg.smooth_len) > MAX_SMOOTH) ? SMOOTH_LEN_W'(NS_CAP)
                                                      : i_cfg.smooth_len;

    assign k_s  = signed'({{(IW-CW){1'b0}}, r_cnt});
    assign i_s  = k_s + IW'(1);
    assign ws_s = signed'({{(IW-CFG_W){1'b0}}, i_cfg.window_start});
    assign we_s = signed'({{(IW-CFG_W){1'b0}}, i_cfg.window_end});
    assign ns_s = signed'({{(IW-SMOOTH_LEN_W){1'b0}}, ns});

    always_comb begin
        case (i_cmd.rd_sel)
            RD_SMOOTH: rd_idx = k_s - ns_s;
            RD_WE:     rd_idx = we_s - IW'(1);
            RD_WS:     rd_idx = ws_s - IW'(1);
            RD_HI:     rd_idx = {{(IW-HT_W){r_hib[HT_W-1]}}, r_hib} - IW'(1);
            RD_LO:     rd_idx = {{(IW-HT_W){r_lowb[HT_W-1]}}, r_lowb} - IW'(1);
            default:   rd_idx = '1;
        endcase
    end

    // A negative index reads as zero
    assign rd_val  = r_rd_zero ? '0 : r_rd_data;
    assign cnt_ok  = (r_cnt < CW'(MAX_SAMPLES));
    assign total_n = r_total + {{(SUM_W-SAMPLE_W){r_x[SAMPLE_W-1]}}, r_x};
    assign m       = total_n - rd_val;

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && cnt_ok) begin
            mem[r_cnt[AW-1:0]] <= total_n;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_idx[AW-1:0]];
            r_rd_zero <= rd_idx[IW-1];
        end
    end

    // End-of-trace window arithmetic
    always_comb begin
        wok_c = (we_s < k_s);
        sok_c = (ws_s >= ns_s) && ((we_s - ns_s) < k_s);
        h_c   = '0;
        if (sok_c && (r_bsum != '0)) begin
            h_c = signed'({3'b000, r_bsidx, 1'b0}) - signed'({5'b00000, ns});
        end
        lo_half = h_c - signed'({3'b000, i_cfg.peak_half_width, 1'b0});
        hi_half = h_c + signed'({3'b000, i_cfg.peak_half_width, 1'b0});
        lowb_c  = half_trunc(lo_half);
        hib_c   = half_trunc(hi_half);
        pok_c   = !lowb_c[HT_W-1] && ({{(IW-HT_W){hib_c[HT_W-1]}}, hib_c} < k_s);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x <= i_sample_value;
        end
        if (i_cmd.calc) begin
            r_wok  <= wok_c;
            r_sok  <= sok_c;
            r_pok  <= pok_c;
            r_h    <= h_c;
            r_lowb <= lowb_c;
            r_hib  <= hib_c;
        end
        case (i_cmd.cap)
            CAP_WE:   r_pa <= rd_val;
            CAP_WS:   r_pb <= rd_val;
            CAP_HI:   r_pc <= rd_val;
            default: begin
            end
        endcase
        if (i_cmd.finish) begin
            o_peak_amplitude        <= r_wok ? r_bamp : '0;
            o_peak_index            <= r_wok ? r_bidx : '0;
            o_window_sum            <= (r_wok && (ws_s < we_s)) ? r_pa - r_pb : '0;
            o_smooth_peak_sum       <= r_sok ? r_bsum[SMOOTH_OUT_W-1:0] : '0;
            o_smooth_peak_half_time <= r_h[TIME_W-1:0];
            o_peak_window_sum       <= (r_pok && (r_lowb < r_hib)) ? r_pc - rd_val : '0;
            o_window_ok             <= r_wok;
            o_smooth_ok             <= r_sok;
            o_peak_window_ok        <= r_pok;
            o_trace_overflow        <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_total <= '0;
            r_cnt   <= '0;
            r_bamp  <= '0;
            r_bidx  <= '0;
            r_bsum  <= '0;
            r_bsidx <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.update) begin
            if (cnt_ok) begin
                r_total <= total_n;
                r_cnt   <= r_cnt + CW'(1);
                if ((ns != '0) && (i_s >= ws_s) && (i_s < we_s)
                        && (mag_sum(m) > mag_sum(r_bsum))) begin
                    r_bsum  <= m;
                    r_bsidx <= i_s[IDX_W-1:0];
                end
                if ((k_s >= ws_s) && (k_s < we_s) && (mag_smp(r_x) > mag_smp(r_bamp))) begin
                    r_bamp <= r_x;
                    r_bidx <= k_s[IDX_W-1:0];
                end
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

endmodule

FILE: hdl/pulse_peak_and_charge_extractor_top.sv
// Pulse peak and charge extractor.
//
// Feed one baseline-subtracted trace sample per request: drive start with
// i_sample_value and i_is_last; the request is taken on a rising edge with
// start high and busy low. A request with i_is_last set closes the trace and
// produces one result; all other requests produce none.
// A plain sample runs a prefix-store read of the moving sum tail, then
// update and write of the single-port prefix store, and busy stays high
// until both are done. The closing sample adds window arithmetic, then four
// prefix-store reads for the fixed and peak-centred window sums, then output.
// The result shows on the o_ result ports with o_valid high for exactly one
// cycle, the first cycle with busy low again. The receiver cannot stall, so
// nothing is held back; the next trace may start in that same cycle.
// Configuration: write i_cfg_wdata to register i_cfg_index (0 window_start,
// 1 window_end, 2 smooth_len, 3 peak_half_width) with i_cfg_we, only while
// busy is low. Writes take effect from the next sample.
// Reset (i_rst_n low at a clock edge) restores register defaults 0, 200, 1,
// 20 and clears the trace; no memory clearing pass is needed.
module pulse_peak_and_charge_extractor_top
    import ppce_pkg::*;
#(
    parameter int MAX_SAMPLES = 256,
    parameter int MAX_SMOOTH  = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [SAMPLE_W-1:0]     i_sample_value,
    input  logic                           i_is_last,
    input  logic                           i_cfg_we,
    input  logic        [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic        [CFG_W-1:0]        i_cfg_wdata,
    output logic                           o_valid,
    output logic signed [SAMPLE_W-1:0]     o_peak_amplitude,
    output logic        [IDX_W-1:0]        o_peak_index,
    output logic signed [SMOOTH_OUT_W-1:0] o_smooth_peak_sum,
    output logic signed [TIME_W-1:0]       o_smooth_peak_half_time,
    output logic signed [SUM_W-1:0]        o_window_sum,
    output logic signed [SUM_W-1:0]        o_peak_window_sum,
    output logic                           o_window_ok,
    output logic                           o_smooth_ok,
    output logic                           o_peak_window_ok,
    output logic                           o_trace_overflow
);

    // Configuration registers
    t_cfg r_cfg;
    // Command bundle from the sequencer to the datapath
    t_cmd cmd;

    // Take a register write; unknown indexes cannot occur with a 2-bit index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_start    <= RST_WINDOW_START;
            r_cfg.window_end      <= RST_WINDOW_END;
            r_cfg.smooth_len      <= RST_SMOOTH_LEN;
            r_cfg.peak_half_width <= RST_PEAK_HALF_WIDTH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WINDOW_START:    r_cfg.window_start    <= i_cfg_wdata;
                REG_WINDOW_END:      r_cfg.window_end      <= i_cfg_wdata;
                REG_SMOOTH_LEN:      r_cfg.smooth_len      <= i_cfg_wdata[SMOOTH_LEN_W-1:0];
                REG_PEAK_HALF_WIDTH: r_cfg.peak_half_width <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Sequence each request: accept, update, and on the last sample the
    // end-of-trace arithmetic and store reads
    ppce_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_is_last (i_is_last),
        .o_busy    (busy),
        .o_valid   (o_valid),
        .o_cmd     (cmd)
    );

    // Hold the prefix-sum store, running peak trackers and result registers
    ppce_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_SMOOTH  (MAX_SMOOTH)
    ) u_dp (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cmd                   (cmd),
        .i_cfg                   (r_cfg),
        .i_sample_value          (i_sample_value),
        .o_peak_amplitude        (o_peak_amplitude),
        .o_peak_index            (o_peak_index),
        .o_smooth_peak_sum       (o_smooth_peak_sum),
        .o_smooth_peak_half_time (o_smooth_peak_half_time),
        .o_window_sum            (o_window_sum),
        .o_peak_window_sum       (o_peak_window_sum),
        .o_window_ok             (o_window_ok),
        .o_smooth_ok             (o_smooth_ok),
        .o_peak_window_ok        (o_peak_window_ok),
        .o_trace_overflow        (o_trace_overflow)
    );

endmodule

FILE: sim/pulse_peak_and_charge_extractor_top_test.sv
module pulse_peak_and_charge_extractor_top_test
    import ppce_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Capacities of the block as instantiated (defaults of the top level)
    localparam int TRACE_CAP  = 256;
    localparam int SMOOTH_CAP = 64;

    // Cycles to let pass once the last result is in.
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES   = 20;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]     peak_amplitude;
        logic        [IDX_W-1:0]        peak_index;
        logic signed [SMOOTH_OUT_W-1:0] smooth_peak_sum;
        logic signed [TIME_W-1:0]       smooth_peak_half_time;
        logic signed [SUM_W-1:0]        window_sum;
        logic signed [SUM_W-1:0]        peak_window_sum;
        logic                           window_ok;
        logic                           smooth_ok;
        logic                           peak_window_ok;
        logic                           trace_overflow;
    } t_pulse_result;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} t_row_kind;

    typedef struct {
        t_row_kind                  kind;
        logic [CFG_IDX_W-1:0]       reg_index;
        logic [CFG_W-1:0]           reg_data;
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
        int                         reps;
        bit                         typed;
        t_pulse_result              expected_res;
    } t_stim_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic signed [SAMPLE_W-1:0]     i_sample_value;
    logic                           i_is_last;
    logic                           i_cfg_we;
    logic        [CFG_IDX_W-1:0]    i_cfg_index;
    logic        [CFG_W-1:0]        i_cfg_wdata;
    logic                           o_valid;
    logic signed [SAMPLE_W-1:0]     o_peak_amplitude;
    logic        [IDX_W-1:0]        o_peak_index;
    logic signed [SMOOTH_OUT_W-1:0] o_smooth_peak_sum;
    logic signed [TIME_W-1:0]       o_smooth_peak_half_time;
    logic signed [SUM_W-1:0]        o_window_sum;
    logic signed [SUM_W-1:0]        o_peak_window_sum;
    logic                           o_window_ok;
    logic                           o_smooth_ok;
    logic                           o_peak_window_ok;
    logic                           o_trace_overflow;

    pulse_peak_and_charge_extractor_top DUT (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .start                   (start),
        .busy                    (busy),
        .i_sample_value          (i_sample_value),
        .i_is_last               (i_is_last),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_wdata             (i_cfg_wdata),
        .o_valid                 (o_valid),
        .o_peak_amplitude        (o_peak_amplitude),
        .o_peak_index            (o_peak_index),
        .o_smooth_peak_sum       (o_smooth_peak_sum),
        .o_smooth_peak_half_time (o_smooth_peak_half_time),
        .o_window_sum            (o_window_sum),
        .o_peak_window_sum       (o_peak_window_sum),
        .o_window_ok             (o_window_ok),
        .o_smooth_ok             (o_smooth_ok),
        .o_peak_window_ok        (o_peak_window_ok),
        .o_trace_overflow        (o_trace_overflow)
    );

    // Mirror of the register file, updated at the edge that writes the block
    logic [CFG_W-1:0]        cfg_window_start    = RST_WINDOW_START;
    logic [CFG_W-1:0]        cfg_window_end      = RST_WINDOW_END;
    logic [SMOOTH_LEN_W-1:0] cfg_smooth_len      = RST_SMOOTH_LEN;
    logic [CFG_W-1:0]        cfg_peak_half_width = RST_PEAK_HALF_WIDTH;

    // Mirror of the per-trace state
    logic signed [SUM_W-1:0]        prefix_mem [TRACE_CAP];
    logic signed [SUM_W-1:0]        trace_total     = '0;
    int                             trace_count     = 0;
    logic signed [SAMPLE_W-1:0]     best_amp        = '0;
    int                             best_amp_idx    = 0;
    logic signed [SMOOTH_OUT_W-1:0] best_smooth     = '0;
    int                             best_smooth_idx = 0;
    bit                             trace_overflow  = 0;

    // Results predicted for closed traces, oldest first
    t_pulse_result pending_results [$];

    int  fail_count      = 0;
    int  reports_shown   = 0;
    int  sender_idle_pct = 0;

    t_pulse_result got_res;
    t_pulse_result want_res;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or drops a result
    initial begin
        #400_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Running sum of samples 0..j of the current trace, zero below the start
    function automatic int prefix_at(input int j);
        if (j < 0 || j >= TRACE_CAP) return 0;
        return int'(prefix_mem[j]);
    endfunction

    // Advance the trace by one sample; on the closing sample fill in the
    // result and clear the trace. Returns whether a result is due.
    function automatic bit predict_pulse(input logic signed [SAMPLE_W-1:0] x,
                                         input logic last,
                                         output t_pulse_result res);
        int xi, ns, ws, we, n, k, m, h, hw, lo_half, lowb, hib;
        int amp, aidx, sps, wsum, psum;
        bit wok, sok, pok;
        xi = x;
        ns = (cfg_smooth_len > SMOOTH_CAP) ? SMOOTH_CAP : int'(cfg_smooth_len);
        ws = int'(cfg_window_start);
        we = int'(cfg_window_end);
        amp = 0; aidx = 0; sps = 0; wsum = 0; psum = 0;
        res = '0;

        if (trace_count < TRACE_CAP) begin
            k = trace_count;
            trace_total = trace_total + xi;
            // trailing moving sum ending just before position k+1
            if (ns > 0) begin
                m = int'(trace_total) - prefix_at(k - ns);
                if (k + 1 >= ws && k + 1 < we && magnitude(m) > magnitude(int'(best_smooth))) begin
                    best_smooth     = m[SMOOTH_OUT_W-1:0];
                    best_smooth_idx = k + 1;
                end
            end
            prefix_mem[k] = trace_total;
            if (k >= ws && k < we && magnitude(xi) > magnitude(int'(best_amp))) begin
                best_amp     = x;
                best_amp_idx = k;
            end
            trace_count++;
        end else begin
            // drop samples past the store capacity
            trace_overflow = 1'b1;
        end

        if (!last) return 1'b0;

        n = trace_count;
        wok = (we < n);
        if (wok) begin
            amp  = best_amp;
            aidx = best_amp_idx;
            if (ws < we) wsum = prefix_at(we - 1) - prefix_at(ws - 1);
        end

        sok = (ws >= ns) && ((we - ns) < n);
        h = 0;
        if (sok) begin
            sps = best_smooth;
            if (best_smooth != 0) h = 2 * best_smooth_idx - ns;
        end

        // bounds of the peak-centred window, halves truncated toward zero
        hw      = int'(cfg_peak_half_width);
        lo_half = h - 2 * hw;
        lowb    = lo_half / 2;
        hib     = (h + 2 * hw) / 2;
        pok     = (lowb >= 0) && (hib < n);
        if (pok && lowb < hib) psum = prefix_at(hib - 1) - prefix_at(lowb - 1);

        res.peak_amplitude        = amp[SAMPLE_W-1:0];
        res.peak_index            = aidx[IDX_W-1:0];
        res.smooth_peak_sum       = sps[SMOOTH_OUT_W-1:0];
        res.smooth_peak_half_time = h[TIME_W-1:0];
        res.window_sum            = wsum[SUM_W-1:0];
        res.peak_window_sum       = psum[SUM_W-1:0];
        res.window_ok             = wok;
        res.smooth_ok             = sok;
        res.peak_window_ok        = pok;
        res.trace_overflow        = trace_overflow;

        trace_total     = '0;
        trace_count     = 0;
        best_amp        = '0;
        best_amp_idx    = 0;
        best_smooth     = '0;
        best_smooth_idx = 0;
        trace_overflow  = 1'b0;
        return 1'b1;
    endfunction

    // Write one register; hold the write enable so that back-to-back writes
    // never lower and raise it within one step. The next request drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            REG_WINDOW_START:    cfg_window_start    = data;
            REG_WINDOW_END:      cfg_window_end      = data;
            REG_SMOOTH_LEN:      cfg_smooth_len      = data[SMOOTH_LEN_W-1:0];
            REG_PEAK_HALF_WIDTH: cfg_peak_half_width = data;
            default: ;
        endcase
    endtask

    // Hold off requests until every predicted result is in and the block
    // has finished any trailing plain samples.
    task automatic settle_block();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Issue one sample request and wait until the block takes it; then
    // advance the predictor and queue the result the block owes, or the
    // typed-in one where the caller gives it.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] v, input logic last,
                               input bit typed, input t_pulse_result typed_res);
        t_pulse_result res;
        bit due;
        i_cfg_we <= 1'b0;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_sample_value <= v;
        i_is_last      <= last;
        do @(posedge i_clk); while (busy);
        due = predict_pulse(v, last, res);
        if (due) pending_results = {pending_results, (typed ? typed_res : res)};
    endtask

    // Random traces: mostly windows that fit the trace, with random
    // register sets and extremes mixed in.
    task automatic run_phase(input int idle_pct, input int item_goal);
        int sent, n, r, style, tmp, ws, we, sl, phw;
        logic signed [SAMPLE_W-1:0] v;
        sent = 0;
        sender_idle_pct = idle_pct;
        while (sent < item_goal) begin
            if ($urandom_range(0, 1) == 0) begin
                settle_block();
                r = $urandom_range(0, 19);
                if (r <= 16) begin
                    ws  = $urandom_range(0, 20);
                    we  = ws + $urandom_range(0, 20);
                    sl  = $urandom_range(0, (ws < SMOOTH_CAP) ? ws : SMOOTH_CAP);
                    phw = $urandom_range(0, 10);
                end else if (r == 17) begin
                    ws  = $urandom_range(0, 255);
                    we  = $urandom_range(0, 255);
                    sl  = $urandom_range(0, 255);
                    phw = $urandom_range(0, 255);
                end else begin
                    ws  = $urandom_range(0, 1) ? 255 : 0;
                    we  = $urandom_range(0, 1) ? 255 : 0;
                    phw = $urandom_range(0, 1) ? 255 : 0;
                    case ($urandom_range(0, 4))
                        0: sl = 0;
                        1: sl = 1;
                        2: sl = SMOOTH_CAP;
                        3: sl = SMOOTH_CAP + 1;
                        default: sl = 127;
                    endcase
                end
                write_reg(REG_WINDOW_START, ws[CFG_W-1:0]);
                write_reg(REG_WINDOW_END, we[CFG_W-1:0]);
                write_reg(REG_SMOOTH_LEN, sl[CFG_W-1:0]);
                write_reg(REG_PEAK_HALF_WIDTH, phw[CFG_W-1:0]);
            end

            // trace length: mostly just past the window end, a few long
            // enough to overrun the store
            r = $urandom_range(0, 99);
            if (r < 75)      n = int'(cfg_window_end) + 1 + $urandom_range(0, 12);
            else if (r < 92) n = $urandom_range(1, 40);
            else if (r < 98) n = $urandom_range(1, TRACE_CAP);
            else             n = $urandom_range(TRACE_CAP + 1, TRACE_CAP + 44);

            style = $urandom_range(0, 9);
            for (int i = 0; i < n; i++) begin
                case (style)
                    5, 6: tmp = $urandom_range(0, 6) - 3;   // small, many ties
                    7: begin
                        case ($urandom_range(0, 3))
                            0: tmp = 32767;
                            1: tmp = -32768;
                            2: tmp = -32767;
                            default: tmp = 0;
                        endcase
                    end
                    8: tmp = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : 0;
                    9: tmp = 0;                            // no peak at all
                    default: tmp = $urandom_range(0, 65535);
                endcase
                v = tmp[SAMPLE_W-1:0];
                send_sample(v, (i == n - 1), 1'b0, '0);
            end
            sent += n;
        end
    endtask

    function automatic t_stim_row row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
        t_stim_row r;
        r = '{kind: ROW_CFG, reg_index: idx, reg_data: data, value: '0, last: 1'b0,
              reps: 0, typed: 1'b0, expected_res: '0};
        return r;
    endfunction

    function automatic t_stim_row row_sample(input logic signed [SAMPLE_W-1:0] v,
                                             input logic last, input int reps);
        t_stim_row r;
        r = '{kind: ROW_SAMPLE, reg_index: '0, reg_data: '0, value: v, last: last,
              reps: reps, typed: 1'b0, expected_res: '0};
        return r;
    endfunction

    // Compare each strobed result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            got_res.peak_amplitude        = o_peak_amplitude;
            got_res.peak_index            = o_peak_index;
            got_res.smooth_peak_sum       = o_smooth_peak_sum;
            got_res.smooth_peak_half_time = o_smooth_peak_half_time;
            got_res.window_sum            = o_window_sum;
            got_res.peak_window_sum       = o_peak_window_sum;
            got_res.window_ok             = o_window_ok;
            got_res.smooth_ok             = o_smooth_ok;
            got_res.peak_window_ok        = o_peak_window_ok;
            got_res.trace_overflow        = o_trace_overflow;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (reports_shown < 10) begin
                    reports_shown++;
                    $display("unexpected result: amp=%0d idx=%0d at %0t",
                             got_res.peak_amplitude, got_res.peak_index, $realtime);
                end
            end else begin
                want_res = pending_results.pop_front();
                if (got_res.peak_amplitude        !== want_res.peak_amplitude        ||
                    got_res.peak_index            !== want_res.peak_index            ||
                    got_res.smooth_peak_sum       !== want_res.smooth_peak_sum       ||
                    got_res.smooth_peak_half_time !== want_res.smooth_peak_half_time ||
                    got_res.window_sum            !== want_res.window_sum            ||
                    got_res.peak_window_sum       !== want_res.peak_window_sum       ||
                    got_res.window_ok             !== want_res.window_ok             ||
                    got_res.smooth_ok             !== want_res.smooth_ok             ||
                    got_res.peak_window_ok        !== want_res.peak_window_ok        ||
                    got_res.trace_overflow        !== want_res.trace_overflow) begin
                    fail_count++;
                    if (reports_shown < 10) begin
                        reports_shown++;
                        $display("mismatch at %0t (amp idx ssum htime wsum pwsum ok:w s p ovf)",
                                 $realtime);
                        $display("  expected %0d %0d %0d %0d %0d %0d %b%b%b%b",
                                 want_res.peak_amplitude, want_res.peak_index,
                                 want_res.smooth_peak_sum, want_res.smooth_peak_half_time,
                                 want_res.window_sum, want_res.peak_window_sum,
                                 want_res.window_ok, want_res.smooth_ok,
                                 want_res.peak_window_ok, want_res.trace_overflow);
                        $display("  actual   %0d %0d %0d %0d %0d %0d %b%b%b%b",
                                 got_res.peak_amplitude, got_res.peak_index,
                                 got_res.smooth_peak_sum, got_res.smooth_peak_half_time,
                                 got_res.window_sum, got_res.peak_window_sum,
                                 got_res.window_ok, got_res.smooth_ok,
                                 got_res.peak_window_ok, got_res.trace_overflow);
                    end
                end
            end
        end
    end

    initial begin
        t_stim_row     dir_rows [$];
        t_stim_row     r;
        t_pulse_result typed_res;
        bit            block_settled;

        // Drive every input from time zero with reset held low
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_sample_value <= '0;
        i_is_last      <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_wdata    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset the window ends at 200: a one-sample trace fails every
        // check and reports all zeros.
        r = row_sample(16'sh7FFF, 1'b1, 1);
        r.typed = 1'b1;
        r.expected_res = '0;
        dir_rows = {dir_rows, r};

        // Tight window [0,2), full-scale samples; the negative extreme wins
        // on its larger magnitude, smoothing fails since start < length.
        dir_rows = {dir_rows, row_cfg(REG_WINDOW_START, 8'd0)};
        dir_rows = {dir_rows, row_cfg(REG_WINDOW_END, 8'd2)};
        dir_rows = {dir_rows, row_cfg(REG_SMOOTH_LEN, 8'd1)};
        dir_rows = {dir_rows, row_cfg(REG_PEAK_HALF_WIDTH, 8'd0)};
        dir_rows = {dir_rows, row_sample(-16'sd32768, 1'b0, 1)};
        dir_rows = {dir_rows, row_sample(16'sd32767, 1'b0, 1)};
        r = row_sample(16'sd1, 1'b1, 1);
        r.typed = 1'b1;
        typed_res = '0;
        typed_res.peak_amplitude = -16'sd32768;
        typed_res.window_sum     = -25'sd1;
        typed_res.window_ok      = 1'b1;
        typed_res.peak_window_ok = 1'b1;
        r.expected_res = typed_res;
        dir_rows = {dir_rows, r};

        // Smoothing off and an all-zero trace: no peak anywhere
        dir_rows = {dir_rows, row_cfg(REG_SMOOTH_LEN, 8'd0)};
        dir_rows = {dir_rows, row_cfg(REG_WINDOW_END, 8'd5)};
        dir_rows = {dir_rows, row_cfg(REG_WINDOW_START, 8'd1)};
        dir_rows = {dir_rows, row_cfg(REG_PEAK_HALF_WIDTH, 8'd1)};
        dir_rows = {dir_rows, row_sample(16'sd0, 1'b0, 6)};
        dir_rows = {dir_rows, row_sample(16'sd0, 1'b1, 1)};

        // Reversed window with a short moving sum
        dir_rows = {dir_rows, row_cfg(REG_WINDOW_START, 8'd3)};
        dir_rows = {dir_rows, row_cfg(REG_WINDOW_END, 8'd2)};
        dir_rows = {dir_rows, row_cfg(REG_SMOOTH_LEN, 8'd2)};
        dir_rows = {dir_rows, row_cfg(REG_PEAK_HALF_WIDTH, 8'd2)};
        dir_rows = {dir_rows, row_sample(-16'sd9, 1'b0, 1)};
        dir_rows = {dir_rows, row_sample(16'sd9, 1'b0, 3)};
        dir_rows = {dir_rows, row_sample(-16'sd32768, 1'b1, 1)};

        // Oversized moving sum saturates; an overlong trace overruns the store
        dir_rows = {dir_rows, row_cfg(REG_SMOOTH_LEN, 8'd127)};
        dir_rows = {dir_rows, row_cfg(REG_WINDOW_START, 8'd100)};
        dir_rows = {dir_rows, row_cfg(REG_WINDOW_END, 8'd250)};
        dir_rows = {dir_rows, row_sample(16'sd100, 1'b0, TRACE_CAP + 44)};
        dir_rows = {dir_rows, row_sample(-16'sd5, 1'b1, 1)};

        sender_idle_pct = 14;
        block_settled = 1'b1;
        foreach (dir_rows[j]) begin
            if (dir_rows[j].kind == ROW_CFG) begin
                // registers only change with the block idle and drained
                if (!block_settled) settle_block();
                write_reg(dir_rows[j].reg_index, dir_rows[j].reg_data);
                block_settled = 1'b1;
            end else begin
                for (int rep = 0; rep < dir_rows[j].reps; rep++)
                    send_sample(dir_rows[j].value,
                                dir_rows[j].last && (rep == dir_rows[j].reps - 1),
                                dir_rows[j].typed, dir_rows[j].expected_res);
                block_settled = 1'b0;
            end
        end

        // Random part in three idling regimes; each reconfiguration drains
        // the block first, so the sender regularly waits for every result.
        run_phase(14, 400);
        run_phase(78, 400);
        run_phase(0, 400);

        // Drain and let the block run out before judging
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
